@@ rtl/droe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagnosis result output encoder package
// Shared types, constants and a lookup function for the encoder core.
// ----------------------------------------------------------------------------
package droe_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    // Command opcodes
    localparam logic [1:0] OP_PUBLISH   = 2'd0;
    localparam logic [1:0] OP_STANDBY   = 2'd1;
    localparam logic [1:0] OP_POWER_OFF = 2'd2;
    localparam logic [1:0] OP_SHUTDOWN  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_RATED_NORMAL = 3'd0;
    localparam logic [2:0] CFG_RATED_BALL   = 3'd1;
    localparam logic [2:0] CFG_RATED_CAGE   = 3'd2;
    localparam logic [2:0] CFG_RATED_OUTER  = 3'd3;
    localparam logic [2:0] CFG_DUTY_SLOPE   = 3'd4;
    localparam logic [2:0] CFG_DUTY_ICPT    = 3'd5;

    // Configuration reset values
    localparam logic [10:0] RATED_NORMAL_RST = 11'd1100;
    localparam logic [10:0] RATED_BALL_RST   = 11'd1400;
    localparam logic [10:0] RATED_CAGE_RST   = 11'd1700;
    localparam logic [10:0] RATED_OUTER_RST  = 11'd2000;
    localparam logic [19:0] DUTY_SLOPE_RST   = 20'd126532;
    localparam logic [20:0] DUTY_ICPT_RST    = 21'd999244;

    // Frame bytes
    localparam logic [7:0] SYNC0           = 8'h55;
    localparam logic [7:0] SYNC1           = 8'hAA;
    localparam logic [7:0] TYPE_RESULT     = 8'h02;
    localparam logic [7:0] TYPE_STATUS     = 8'h01;
    localparam logic [7:0] CLASS_STANDBY   = 8'h05;
    localparam logic [7:0] CLASS_POWER_OFF = 8'hFF;
    localparam logic [7:0] LEDS_OFF        = 8'hFF;

    // Current and duty constants (centi-mA, millionths)
    localparam logic [10:0] CUR_MIN    = 11'd400;
    localparam logic [10:0] CUR_MAX    = 11'd2000;
    localparam logic [10:0] CUR_BASE   = 11'd800;
    localparam logic [10:0] CUR_FAIL   = 11'd500;
    localparam logic [13:0] CONF_FULL  = 14'd10000;
    localparam logic [19:0] DUTY_FULL  = 20'd1000000;
    localparam logic [19:0] DUTY_RST   = 20'd801538;
    localparam logic [23:0] ROUND_HALF = 24'd5000;

    // floor(2^37 / 10000): quotient estimate is exact or one low
    localparam int          RECIP_SHIFT = 37;
    localparam logic [23:0] RECIP_K     = 24'd13743895;
    // ceil(2^19 / 100): exact split of an 11-bit centi value into mA
    localparam logic [12:0] HUND_K      = 13'd5243;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_RECIP,
        ST_QMUL,
        ST_ROUND,
        ST_DMUL,
        ST_DFIN,
        ST_SEND
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             mult;
        logic             recip;
        logic             qmul;
        logic             round;
        logic             dmul;
        logic             dfin;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;   // repeated power-off, no words
        logic last;   // current word closes the command
    } dp_status_t;

    // Active-low LED pattern per valid class, invalid lights bit 6 only
    function automatic logic [7:0] leds_for(input logic [7:0] cls);
        logic [7:0] leds;
        case (cls)
            8'd0:    leds = 8'hFE;
            8'd1:    leds = 8'h2F;
            8'd2:    leds = 8'h37;
            8'd3:    leds = 8'h3D;
            default: leds = 8'hBF;
        endcase
        return leds;
    endfunction

endpackage

@@ rtl/droe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder controller
// Sequences the arithmetic steps of one command and serializes its frame.
// ----------------------------------------------------------------------------
module droe_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  droe_pkg::dp_status_t status,
    output droe_pkg::dp_cmd_t    cmd
);

    droe_pkg::state_t                 state_reg, state_next;
    logic [droe_pkg::IDX_W-1:0]       idx_reg, idx_next;

    // State and word counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= droe_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            droe_pkg::ST_IDLE: begin
                if (s_valid && !status.skip) begin
                    state_next = droe_pkg::ST_MULT;
                end
            end
            droe_pkg::ST_MULT:  state_next = droe_pkg::ST_RECIP;
            droe_pkg::ST_RECIP: state_next = droe_pkg::ST_QMUL;
            droe_pkg::ST_QMUL:  state_next = droe_pkg::ST_ROUND;
            droe_pkg::ST_ROUND: state_next = droe_pkg::ST_DMUL;
            droe_pkg::ST_DMUL:  state_next = droe_pkg::ST_DFIN;
            droe_pkg::ST_DFIN:  state_next = droe_pkg::ST_SEND;
            droe_pkg::ST_SEND: begin
                if (m_ready) begin
                    if (status.last) begin
                        state_next = droe_pkg::ST_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = droe_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd       = '0;
        cmd.idx   = idx_reg;
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        case (state_reg)
            droe_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            droe_pkg::ST_MULT:  cmd.mult  = 1'b1;
            droe_pkg::ST_RECIP: cmd.recip = 1'b1;
            droe_pkg::ST_QMUL:  cmd.qmul  = 1'b1;
            droe_pkg::ST_ROUND: cmd.round = 1'b1;
            droe_pkg::ST_DMUL:  cmd.dmul  = 1'b1;
            droe_pkg::ST_DFIN:  cmd.dfin  = 1'b1;
            droe_pkg::ST_SEND:  m_valid   = 1'b1;
            default: ;
        endcase
    end

endmodule

@@ rtl/droe_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder datapath
// Config registers, current mapping, duty computation and frame assembly.
// ----------------------------------------------------------------------------
module droe_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [20:0]          cfg_data,
    input  logic [1:0]           s_opcode,
    input  logic [7:0]           s_class_id,
    input  logic [15:0]          s_confidence,
    input  droe_pkg::dp_cmd_t    cmd,
    output droe_pkg::dp_status_t status,
    output logic [7:0]           m_frame_byte,
    output logic                 m_frame_valid,
    output logic                 m_last_byte,
    output logic [19:0]          m_pwm_duty,
    output logic [10:0]          m_loop_current_centi,
    output logic                 m_relay_on,
    output logic [7:0]           m_led_lines
);

    // Configuration
    logic [10:0] rated_normal_reg, rated_ball_reg, rated_cage_reg, rated_outer_reg;
    logic [19:0] slope_reg;
    logic [20:0] icpt_reg;

    // Command capture and held outputs
    logic [1:0]  op_reg;
    logic [7:0]  cls_reg;
    logic [13:0] conf_reg;
    logic        latch_reg;
    logic [19:0] duty_reg;
    logic        relay_reg;
    logic [7:0]  leds_reg;

    // Arithmetic pipeline registers
    logic signed [25:0] delta_reg;
    logic        neg_reg;
    logic [23:0] m_reg;
    logic [47:0] prod_reg;
    logic [10:0] qest_reg;
    logic [23:0] qm_reg;
    logic [10:0] centi_reg;
    logic [7:0]  type_reg;
    logic [7:0]  clsb_reg;
    logic [13:0] confo_reg;
    logic [30:0] dprod_reg;
    logic [4:0]  hq_reg;
    logic [6:0]  rem_reg;

    // Combinational intermediates
    logic [13:0]        conf_sat;
    logic [10:0]        rated_sel;
    logic signed [11:0] diff;
    logic signed [25:0] delta;
    logic [23:0]        mag;
    logic [23:0]        m_val;
    logic [24:0]        qm_full;
    logic [23:0]        rem_big;
    logic [10:0]        q_val;
    logic [10:0]        pub_centi;
    logic               class_ok;
    logic [10:0]        cc;
    logic [30:0]        dprod;
    logic [23:0]        hprod;
    logic [22:0]        sub;
    logic [20:0]        dif;
    logic [19:0]        duty_val;
    logic [10:0]        hq100;
    logic [10:0]        rem_full;
    logic [7:0]         frame_sel;
    logic               single;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rated_normal_reg <= droe_pkg::RATED_NORMAL_RST;
            rated_ball_reg   <= droe_pkg::RATED_BALL_RST;
            rated_cage_reg   <= droe_pkg::RATED_CAGE_RST;
            rated_outer_reg  <= droe_pkg::RATED_OUTER_RST;
            slope_reg        <= droe_pkg::DUTY_SLOPE_RST;
            icpt_reg         <= droe_pkg::DUTY_ICPT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                droe_pkg::CFG_RATED_NORMAL: rated_normal_reg <= cfg_data[10:0];
                droe_pkg::CFG_RATED_BALL:   rated_ball_reg   <= cfg_data[10:0];
                droe_pkg::CFG_RATED_CAGE:   rated_cage_reg   <= cfg_data[10:0];
                droe_pkg::CFG_RATED_OUTER:  rated_outer_reg  <= cfg_data[10:0];
                droe_pkg::CFG_DUTY_SLOPE:   slope_reg        <= cfg_data[19:0];
                droe_pkg::CFG_DUTY_ICPT:    icpt_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input capture and power-off latch
    assign conf_sat = (s_confidence > 16'(droe_pkg::CONF_FULL)) ?
                      droe_pkg::CONF_FULL : s_confidence[13:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= 1'b0;
        end else if (cmd.load && (s_opcode == droe_pkg::OP_POWER_OFF)) begin
            latch_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_opcode;
            cls_reg  <= s_class_id;
            conf_reg <= conf_sat;
        end
    end

    // Signed offset from the 8 mA base times confidence
    always_comb begin
        case (cls_reg[1:0])
            2'd0:    rated_sel = rated_normal_reg;
            2'd1:    rated_sel = rated_ball_reg;
            2'd2:    rated_sel = rated_cage_reg;
            default: rated_sel = rated_outer_reg;
        endcase
        diff  = $signed({1'b0, rated_sel}) - $signed({1'b0, droe_pkg::CUR_BASE});
        delta = diff * $signed({1'b0, conf_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            delta_reg <= delta;
        end
    end

    // Magnitude plus half, times reciprocal of 10000
    assign mag   = delta_reg[25] ? 24'(-delta_reg) : delta_reg[23:0];
    assign m_val = mag + droe_pkg::ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (cmd.recip) begin
            neg_reg  <= delta_reg[25];
            m_reg    <= m_val;
            prod_reg <= m_val * droe_pkg::RECIP_K;
        end
    end

    // Quotient estimate and its back-multiply
    assign qm_full = prod_reg[47:droe_pkg::RECIP_SHIFT] * 14'd10000;

    always_ff @(posedge aclk) begin
        if (cmd.qmul) begin
            qest_reg <= prod_reg[47:droe_pkg::RECIP_SHIFT];
            qm_reg   <= qm_full[23:0];
        end
    end

    // Correct the estimate and pick the command's current and frame fields
    assign rem_big   = m_reg - qm_reg;
    assign q_val     = qest_reg + ((rem_big >= 24'd10000) ? 11'd1 : 11'd0);
    assign pub_centi = neg_reg ? (droe_pkg::CUR_BASE - q_val)
                               : (droe_pkg::CUR_BASE + q_val);
    assign class_ok  = (cls_reg[7:2] == 6'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_reg <= 1'b0;
            leds_reg  <= droe_pkg::LEDS_OFF;
        end else if (cmd.round) begin
            case (op_reg)
                droe_pkg::OP_PUBLISH: begin
                    relay_reg <= (cls_reg != 8'd0);
                    leds_reg  <= droe_pkg::leds_for(cls_reg);
                end
                default: begin
                    relay_reg <= 1'b0;
                    leds_reg  <= droe_pkg::LEDS_OFF;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            case (op_reg)
                droe_pkg::OP_PUBLISH: begin
                    centi_reg <= class_ok ? pub_centi : droe_pkg::CUR_FAIL;
                    type_reg  <= droe_pkg::TYPE_RESULT;
                    clsb_reg  <= cls_reg;
                    confo_reg <= conf_reg;
                end
                droe_pkg::OP_STANDBY: begin
                    centi_reg <= droe_pkg::CUR_FAIL;
                    type_reg  <= droe_pkg::TYPE_STATUS;
                    clsb_reg  <= droe_pkg::CLASS_STANDBY;
                    confo_reg <= '0;
                end
                droe_pkg::OP_POWER_OFF: begin
                    centi_reg <= droe_pkg::CUR_MIN;
                    type_reg  <= droe_pkg::TYPE_STATUS;
                    clsb_reg  <= droe_pkg::CLASS_POWER_OFF;
                    confo_reg <= '0;
                end
                default: begin
                    centi_reg <= droe_pkg::CUR_MIN;
                    type_reg  <= droe_pkg::TYPE_STATUS;
                    clsb_reg  <= '0;
                    confo_reg <= '0;
                end
            endcase
        end
    end

    // Duty product on the clamped current, mA split of the current
    assign cc    = (centi_reg < droe_pkg::CUR_MIN) ? droe_pkg::CUR_MIN :
                   (centi_reg > droe_pkg::CUR_MAX) ? droe_pkg::CUR_MAX : centi_reg;
    assign dprod = slope_reg * cc + 31'd128;
    assign hprod = centi_reg * droe_pkg::HUND_K;

    always_ff @(posedge aclk) begin
        if (cmd.dmul) begin
            dprod_reg <= dprod;
            hq_reg    <= hprod[23:19];
        end
    end

    // Duty subtract, floor at zero, cap at full scale; centi-mA remainder
    assign sub      = dprod_reg[30:8];
    assign dif      = icpt_reg - sub[20:0];
    assign duty_val = (sub >= {2'b00, icpt_reg})        ? 20'd0 :
                      (dif > 21'(droe_pkg::DUTY_FULL))  ? droe_pkg::DUTY_FULL :
                                                          dif[19:0];
    assign hq100    = 11'(hq_reg * 7'd100);
    assign rem_full = centi_reg - hq100;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= droe_pkg::DUTY_RST;
        end else if (cmd.dfin) begin
            duty_reg <= duty_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dfin) begin
            rem_reg <= rem_full[6:0];
        end
    end

    // Frame word select
    always_comb begin
        case (cmd.idx)
            3'd0:    frame_sel = droe_pkg::SYNC0;
            3'd1:    frame_sel = droe_pkg::SYNC1;
            3'd2:    frame_sel = type_reg;
            3'd3:    frame_sel = clsb_reg;
            3'd4:    frame_sel = {2'b00, confo_reg[13:8]};
            3'd5:    frame_sel = confo_reg[7:0];
            3'd6:    frame_sel = {3'b000, hq_reg};
            default: frame_sel = {1'b0, rem_reg};
        endcase
    end

    assign single = (op_reg == droe_pkg::OP_SHUTDOWN);

    assign status.skip = (s_opcode == droe_pkg::OP_POWER_OFF) && latch_reg;
    assign status.last = single || (cmd.idx == droe_pkg::LAST_IDX);

    assign m_frame_byte         = single ? 8'd0 : frame_sel;
    assign m_frame_valid        = !single;
    assign m_last_byte          = status.last;
    assign m_pwm_duty           = duty_reg;
    assign m_loop_current_centi = centi_reg;
    assign m_relay_on           = relay_reg;
    assign m_led_lines          = leds_reg;

endmodule

@@ rtl/diagnosis_result_output_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagnosis result output encoder core
// Maps a diagnosis command to loop current, PWM duty, relay and LEDs, and
// sends the matching eight-word status frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one command word (opcode, class, confidence) per
//   valid/ready handshake. m_* channel returns one frame word per handshake,
//   eight words per publish, standby or first power-off command, with the
//   held duty, current, relay and LED state on every word. Shutdown returns
//   a single word with m_frame_valid low. A repeated power-off returns none.
//   The first word is shown once the command has passed six arithmetic
//   steps (MULT, RECIP, QMUL, ROUND, DMUL, DFIN) on one shared datapath.
//   s_ready is high only between commands. m_ready low simply holds the
//   current word; nothing is dropped. cfg_wr_en writes register cfg_index
//   from cfg_data; the user is to write only when idle, which the block
//   itself does not enforce. Reset (aresetn low, synchronous) restores
//   register defaults, clears the power-off latch and sets duty, relay and
//   LEDs to the 4 mA safe state; the loop current output is not reset.
// ----------------------------------------------------------------------------
module diagnosis_result_output_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_class_id,
    input  logic [15:0] s_confidence,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_frame_valid,
    output logic        m_last_byte,
    output logic [19:0] m_pwm_duty,
    output logic [10:0] m_loop_current_centi,
    output logic        m_relay_on,
    output logic [7:0]  m_led_lines
);

    droe_pkg::dp_cmd_t    cmd;
    droe_pkg::dp_status_t status;

    // Sequencer
    droe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and frame assembly
    droe_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_opcode             (s_opcode),
        .s_class_id           (s_class_id),
        .s_confidence         (s_confidence),
        .cmd                  (cmd),
        .status               (status),
        .m_frame_byte         (m_frame_byte),
        .m_frame_valid        (m_frame_valid),
        .m_last_byte          (m_last_byte),
        .m_pwm_duty           (m_pwm_duty),
        .m_loop_current_centi (m_loop_current_centi),
        .m_relay_on           (m_relay_on),
        .m_led_lines          (m_led_lines)
    );

endmodule

@@ rtl/droe_sva.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder port checker
// Port-level properties of the encoder core, attached by bind.
// ----------------------------------------------------------------------------
module droe_sva (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_frame_byte,
    input logic        m_frame_valid,
    input logic        m_last_byte,
    input logic [19:0] m_pwm_duty
);

    // One command at a time: never taking input while a word is shown
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result word is pending");

    // A shutdown word is always the only word of its command
    a_shutdown_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_valid) |-> m_last_byte)
        else $error("non-frame word not marked last");

    // A frame keeps going until its last word
    a_frame_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_byte) |=> m_valid)
        else $error("frame broken before last word");

    // Stalled word holds its byte
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_frame_byte))
        else $error("frame byte changed under stall");

    // Duty never exceeds full scale while a word is shown
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pwm_duty <= 20'd1000000))
        else $error("duty above full scale");

endmodule

bind diagnosis_result_output_encoder_core droe_sva u_droe_sva (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_frame_byte  (m_frame_byte),
    .m_frame_valid (m_frame_valid),
    .m_last_byte   (m_last_byte),
    .m_pwm_duty    (m_pwm_duty)
);

@@ tb/diagnosis_result_output_encoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagnosis result output encoder core testbench
// Sends publish, standby, power-off and shutdown commands under several
// register settings and checks every frame word against a local
// loop-current, duty and frame predictor. Both channels idle and stall at
// random, and one long receiver hold backs the block up into its input.
// ----------------------------------------------------------------------------
module diagnosis_result_output_encoder_core_tb;

    localparam int          N_DIRECTED    = 20;
    localparam int          PHASE_ITEMS   = 51;
    localparam int          N_PHASES      = 9;
    localparam int          LONG_HOLD     = 300;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_CYCLES  = 24;
    localparam logic [2:0]  CFG_SPARE_A   = 3'd6;
    localparam logic [2:0]  CFG_SPARE_B   = 3'd7;

    // One frame word as it leaves the m_ channel
    typedef struct packed {
        logic [7:0]  fbyte;
        logic        fvalid;
        logic        last;
        logic [19:0] duty;
        logic [10:0] centi;
        logic        relay;
        logic [7:0]  leds;
    } frame_word_t;

    // Directed command; pinned rows carry current and duty read off by hand
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cls;
        logic [15:0] conf;
        logic        pinned;
        logic [10:0] centi;
        logic [19:0] duty;
    } dir_row_t;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{droe_pkg::OP_STANDBY,   8'h00, 16'h0000, 1'b1, 11'd500,  20'd752111},
        '{droe_pkg::OP_PUBLISH,   8'h00, 16'd0,    1'b1, 11'd800,  20'd603831},
        '{droe_pkg::OP_PUBLISH,   8'h00, 16'hFFFF, 1'b1, 11'd1100, 20'd455552},
        '{droe_pkg::OP_PUBLISH,   8'h03, 16'd10000, 1'b1, 11'd2000, 20'd10713},
        '{droe_pkg::OP_PUBLISH,   8'h01, 16'd5000, 1'b0, 11'd0,    20'd0},
        '{droe_pkg::OP_PUBLISH,   8'h02, 16'd10001, 1'b0, 11'd0,   20'd0},
        '{droe_pkg::OP_PUBLISH,   8'h03, 16'd9999, 1'b0, 11'd0,    20'd0},
        '{droe_pkg::OP_PUBLISH,   8'h04, 16'd1234, 1'b1, 11'd500,  20'd752111},
        '{droe_pkg::OP_PUBLISH,   8'hFF, 16'hFFFF, 1'b1, 11'd500,  20'd752111},
        '{droe_pkg::OP_PUBLISH,   8'h80, 16'd0,    1'b1, 11'd500,  20'd752111},
        '{droe_pkg::OP_SHUTDOWN,  8'hFF, 16'hFFFF, 1'b1, 11'd400,  20'd801538},
        '{droe_pkg::OP_PUBLISH,   8'h01, 16'd1,    1'b0, 11'd0,    20'd0},
        '{droe_pkg::OP_POWER_OFF, 8'h00, 16'h0000, 1'b1, 11'd400,  20'd801538},
        '{droe_pkg::OP_POWER_OFF, 8'h03, 16'h1234, 1'b0, 11'd0,    20'd0},
        '{droe_pkg::OP_STANDBY,   8'hFF, 16'hFFFF, 1'b1, 11'd500,  20'd752111},
        '{droe_pkg::OP_PUBLISH,   8'h02, 16'd6,    1'b0, 11'd0,    20'd0},
        '{droe_pkg::OP_SHUTDOWN,  8'h00, 16'h0000, 1'b1, 11'd400,  20'd801538},
        '{droe_pkg::OP_POWER_OFF, 8'hFF, 16'hFFFF, 1'b0, 11'd0,    20'd0},
        '{droe_pkg::OP_PUBLISH,   8'h03, 16'hAAAA, 1'b0, 11'd0,    20'd0},
        '{droe_pkg::OP_PUBLISH,   8'h55, 16'h5555, 1'b1, 11'd500,  20'd752111}
    };

    // DUT connections, all inputs known from time zero
    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [20:0] cfg_data     = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode     = '0;
    logic [7:0]  s_class_id   = '0;
    logic [15:0] s_confidence = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_frame_byte;
    logic        m_frame_valid;
    logic        m_last_byte;
    logic [19:0] m_pwm_duty;
    logic [10:0] m_loop_current_centi;
    logic        m_relay_on;
    logic [7:0]  m_led_lines;

    // Predictor copy of registers and state
    logic [10:0] rated_centi [4];
    logic [19:0] duty_slope;
    logic [20:0] duty_icpt;
    logic        pwr_off_latched;

    frame_word_t frame_words_q [$];
    frame_word_t got_word;
    frame_word_t want_word;

    int  mismatches    = 0;
    int  words_checked = 0;
    int  cmds_taken    = 0;
    int  settings_used = 1;
    bit  stall_req     = 1'b0;
    bit  no_idle       = 1'b0;

    diagnosis_result_output_encoder_core dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_opcode             (s_opcode),
        .s_class_id           (s_class_id),
        .s_confidence         (s_confidence),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_frame_byte         (m_frame_byte),
        .m_frame_valid        (m_frame_valid),
        .m_last_byte          (m_last_byte),
        .m_pwm_duty           (m_pwm_duty),
        .m_loop_current_centi (m_loop_current_centi),
        .m_relay_on           (m_relay_on),
        .m_led_lines          (m_led_lines)
    );

    // Clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Duty in millionths for a current, clamped to the loop range
    function automatic logic [19:0] duty_at(input logic [10:0] centi);
        longint unsigned c;
        longint unsigned sub;
        longint unsigned icpt;
        c    = centi;
        icpt = duty_icpt;
        if (c < droe_pkg::CUR_MIN) c = droe_pkg::CUR_MIN;
        if (c > droe_pkg::CUR_MAX) c = droe_pkg::CUR_MAX;
        sub = (longint'(duty_slope) * c + 128) >> 8;
        if (sub >= icpt) return '0;
        if (icpt - sub > droe_pkg::DUTY_FULL) return droe_pkg::DUTY_FULL;
        return 20'(icpt - sub);
    endfunction

    // Publish current: base plus rated span times confidence, rounded half away
    function automatic logic [10:0] loop_centi_for(input logic [7:0] cls,
                                                   input logic [13:0] conf);
        longint rated;
        longint delta;
        longint q;
        if (cls > 8'd3) return droe_pkg::CUR_FAIL;
        rated = longint'(rated_centi[cls[1:0]]);
        delta = (rated - longint'(droe_pkg::CUR_BASE)) * longint'(conf);
        if (delta >= 0) q = (delta + 5000) / 10000;
        else q = -((-delta + 5000) / 10000);
        return 11'(longint'(droe_pkg::CUR_BASE) + q);
    endfunction

    // Active-low LED byte per class
    function automatic logic [7:0] led_pattern(input logic [7:0] cls);
        case (cls)
            8'd0:    return ~8'b0000_0001;
            8'd1:    return ~8'b1101_0000;
            8'd2:    return ~8'b1100_1000;
            8'd3:    return ~8'b1100_0010;
            default: return ~8'b0100_0000;
        endcase
    endfunction

    // Work out the frame words one command causes and queue them
    function automatic void encode_command(input logic [1:0]  op,
                                           input logic [7:0]  cls,
                                           input logic [15:0] conf_in,
                                           input logic        pinned,
                                           input logic [10:0] pin_centi,
                                           input logic [19:0] pin_duty);
        logic [13:0] conf;
        logic [10:0] centi;
        logic [19:0] duty;
        logic        relay;
        logic [7:0]  leds;
        logic [7:0]  ftype;
        logic [7:0]  fclass;
        logic [15:0] fconf;
        logic [7:0]  fbyte;
        frame_word_t w;
        conf   = (conf_in > 16'(droe_pkg::CONF_FULL)) ? droe_pkg::CONF_FULL : conf_in[13:0];
        relay  = 1'b0;
        leds   = droe_pkg::LEDS_OFF;
        ftype  = droe_pkg::TYPE_STATUS;
        fconf  = '0;
        fclass = cls;
        centi  = droe_pkg::CUR_MIN;
        case (op)
            droe_pkg::OP_PUBLISH: begin
                centi = loop_centi_for(cls, conf);
                relay = (cls != 8'd0);
                leds  = led_pattern(cls);
                ftype = droe_pkg::TYPE_RESULT;
                fconf = {2'b00, conf};
            end
            droe_pkg::OP_STANDBY: begin
                centi  = droe_pkg::CUR_FAIL;
                fclass = droe_pkg::CLASS_STANDBY;
            end
            droe_pkg::OP_POWER_OFF: begin
                // latched power-off is dropped without a word
                if (pwr_off_latched) return;
                pwr_off_latched = 1'b1;
                fclass = droe_pkg::CLASS_POWER_OFF;
            end
            default: ;
        endcase
        duty = duty_at(centi);
        if (pinned) begin
            centi = pin_centi;
            duty  = pin_duty;
        end
        if (op == droe_pkg::OP_SHUTDOWN) begin
            frame_words_q.push_back({8'h00, 1'b0, 1'b1, duty, centi, 1'b0,
                                     droe_pkg::LEDS_OFF});
            return;
        end
        for (int k = 0; k < droe_pkg::FRAME_BYTES; k++) begin
            case (k)
                0:       fbyte = droe_pkg::SYNC0;
                1:       fbyte = droe_pkg::SYNC1;
                2:       fbyte = ftype;
                3:       fbyte = fclass;
                4:       fbyte = fconf[15:8];
                5:       fbyte = fconf[7:0];
                6:       fbyte = 8'(centi / 100);
                default: fbyte = 8'(centi % 100);
            endcase
            w = {fbyte, 1'b1, (k == droe_pkg::FRAME_BYTES - 1), duty, centi, relay, leds};
            frame_words_q.push_back(w);
        end
    endfunction

    // Idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_confidence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(0, 10000));
        if (r < 70) return 16'($urandom_range(10000, 65535));
        if (r < 80) begin
            case ($urandom_range(0, 2))
                0:       return 16'd0;
                1:       return 16'd10000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Offer one command word; valid stays up when no gap follows
    task automatic send_cmd(input logic [1:0]  op,
                            input logic [7:0]  cls,
                            input logic [15:0] conf,
                            input logic        pinned,
                            input logic [10:0] pin_centi,
                            input logic [19:0] pin_duty,
                            input int          gap);
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_class_id   <= cls;
        s_confidence <= conf;
        do @(posedge aclk); while (!s_ready);
        cmds_taken++;
        encode_command(op, cls, conf, pinned, pin_centi, pin_duty);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [20:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            droe_pkg::CFG_RATED_NORMAL: rated_centi[0] = data[10:0];
            droe_pkg::CFG_RATED_BALL:   rated_centi[1] = data[10:0];
            droe_pkg::CFG_RATED_CAGE:   rated_centi[2] = data[10:0];
            droe_pkg::CFG_RATED_OUTER:  rated_centi[3] = data[10:0];
            droe_pkg::CFG_DUTY_SLOPE:   duty_slope     = data[19:0];
            droe_pkg::CFG_DUTY_ICPT:    duty_icpt      = data;
            default: ;
        endcase
    endtask

    // Wait for the block to drain, then load a full register set
    task automatic apply_setting(input logic [20:0] r0, input logic [20:0] r1,
                                 input logic [20:0] r2, input logic [20:0] r3,
                                 input logic [20:0] slope, input logic [20:0] icpt,
                                 input bit spare);
        s_valid <= 1'b0;
        while (frame_words_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(droe_pkg::CFG_RATED_NORMAL, r0);
        write_reg(droe_pkg::CFG_RATED_BALL, r1);
        write_reg(droe_pkg::CFG_RATED_CAGE, r2);
        write_reg(droe_pkg::CFG_RATED_OUTER, r3);
        write_reg(droe_pkg::CFG_DUTY_SLOPE, slope);
        write_reg(droe_pkg::CFG_DUTY_ICPT, icpt);
        if (spare) begin
            // unused indexes must not disturb anything
            write_reg(CFG_SPARE_A, 21'($urandom));
            write_reg(CFG_SPARE_B, 21'($urandom));
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Random commands; the first burst words go out back to back
    task automatic run_random(input int n, input int burst);
        logic [1:0]  op;
        logic [7:0]  cls;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) op = droe_pkg::OP_PUBLISH;
            else if (r < 75) op = droe_pkg::OP_STANDBY;
            else if (r < 85) op = droe_pkg::OP_POWER_OFF;
            else op = droe_pkg::OP_SHUTDOWN;
            cls = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_cmd(op, cls, pick_confidence(), 1'b0, '0, '0,
                     (i < burst) ? 0 : pick_gap());
        end
    endtask

    // Receiver: random ready pattern, one long hold on request
    initial begin
        int run;
        int gap;
        wait (aresetn);
        forever begin
            if (stall_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                stall_req = 1'b0;
            end else begin
                m_ready <= 1'b1;
                run = no_idle ? 16 : $urandom_range(1, 12);
                repeat (run) @(posedge aclk);
                gap = pick_gap();
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Frame word checker
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got_word = {m_frame_byte, m_frame_valid, m_last_byte, m_pwm_duty,
                        m_loop_current_centi, m_relay_on, m_led_lines};
            if (frame_words_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, actual byte=%h fv=%b last=%b duty=%0d",
                         $time, got_word.fbyte, got_word.fvalid, got_word.last,
                         got_word.duty);
            end else begin
                want_word = frame_words_q.pop_front();
                words_checked++;
                if (got_word !== want_word) begin
                    mismatches++;
                    $display("%0t: word mismatch expected byte=%h fv=%b last=%b duty=%0d",
                             $time, want_word.fbyte, want_word.fvalid, want_word.last,
                             want_word.duty);
                    $display("    centi=%0d relay=%b leds=%h | actual byte=%h fv=%b last=%b",
                             want_word.centi, want_word.relay, want_word.leds,
                             got_word.fbyte, got_word.fvalid, got_word.last);
                    $display("    duty=%0d centi=%0d relay=%b leds=%h",
                             got_word.duty, got_word.centi, got_word.relay,
                             got_word.leds);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        rated_centi     = '{droe_pkg::RATED_NORMAL_RST, droe_pkg::RATED_BALL_RST,
                            droe_pkg::RATED_CAGE_RST, droe_pkg::RATED_OUTER_RST};
        duty_slope      = droe_pkg::DUTY_SLOPE_RST;
        duty_icpt       = droe_pkg::DUTY_ICPT_RST;
        pwr_off_latched = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed commands under reset registers
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_cmd(DIRECTED[i].op, DIRECTED[i].cls, DIRECTED[i].conf,
                     DIRECTED[i].pinned, DIRECTED[i].centi, DIRECTED[i].duty,
                     pick_gap());
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: ;
                1: apply_setting(21'd400, 21'd400, 21'd400, 21'd400,
                                 21'd0, 21'd2000000, 1'b0);
                2: apply_setting(21'd2000, 21'd2000, 21'd2000, 21'd2000,
                                 21'd1048575, 21'd0, 1'b0);
                3: apply_setting(21'd0, 21'd2047, 21'd799, 21'd801,
                                 21'h80000, 21'h1FFFFF, 1'b0);
                4: apply_setting(21'($urandom), 21'($urandom), 21'($urandom),
                                 21'($urandom), 21'($urandom), 21'($urandom), 1'b1);
                8: apply_setting(21'(droe_pkg::RATED_NORMAL_RST),
                                 21'(droe_pkg::RATED_BALL_RST),
                                 21'(droe_pkg::RATED_CAGE_RST),
                                 21'(droe_pkg::RATED_OUTER_RST),
                                 21'(droe_pkg::DUTY_SLOPE_RST),
                                 21'(droe_pkg::DUTY_ICPT_RST), 1'b0);
                default: apply_setting(21'($urandom_range(400, 2000)),
                                       21'($urandom_range(400, 2000)),
                                       21'($urandom_range(400, 2000)),
                                       21'($urandom_range(400, 2000)),
                                       21'($urandom_range(50000, 300000)),
                                       21'($urandom_range(500000, 2000000)), 1'b0);
            endcase
            no_idle = (ph == 5);
            if (ph == 2) begin
                // receiver backs off while commands keep coming
                stall_req = 1'b1;
                run_random(PHASE_ITEMS, 30);
            end else begin
                run_random(PHASE_ITEMS, 0);
            end
        end
        no_idle = 1'b0;

        s_valid <= 1'b0;
        while (frame_words_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d commands across %0d register settings, %0d frame words checked,",
                 cmds_taken, settings_used, words_checked);
        $display("with random idling on both channels and one long receiver hold.");
        if (mismatches == 0 && frame_words_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
